// ===== rtl/e2c_pkg.sv =====
// Package for the epoch seconds to calendar converter: state, command and status types,
// calendar constants, reciprocal constants and month lengths shared by controller and datapath.
// Depends on nothing.
package e2c_pkg;

   // Calendar constants.
   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned DaysPerWeek = 7;
   localparam logic [11:0] EpochYear   = 12'd1970;
   localparam logic [2:0]  EpochWday   = 3'd4;
   // Within 1970..2106 the only century year that is not a leap year is 2100.
   localparam logic [11:0] NonLeapCentury = 12'd2100;
   localparam logic [3:0]  LastMonth      = 4'd11;

   // Reciprocals for division by a constant, each 2^k / d rounded up and exact over the
   // operand range it sees. 86400 is 128 * 675, 3600 is 16 * 225 and 60 is 4 * 15, so the
   // low bits are shifted off first.
   localparam logic [25:0] DayRecip  = 26'd50903317; // 2^35 / 675
   localparam logic [16:0] WeekRecip = 17'd74899;    // 2^19 / 7
   localparam logic [13:0] HourRecip = 14'd9321;     // 2^21 / 225
   localparam logic [10:0] MinRecip  = 11'd1093;     // 2^14 / 15

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAY,
      ST_SOD,
      ST_HOUR,
      ST_HREM,
      ST_MIN,
      ST_SEC,
      ST_YEARS,
      ST_MONTHS,
      ST_DONE
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DAY,
      OP_SOD,
      OP_HOUR,
      OP_HREM,
      OP_MIN,
      OP_SEC,
      OP_YEAR,
      OP_MONTH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic year_stop;
      logic month_stop;
   } stat_type;

   // Days in month (0 is January), February lengthened in a leap year.
   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3,
         4'd5,
         4'd8,
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to calendar converter: joins controller and datapath.
// A transaction runs six multiply and subtract steps, then the year loop, which steps once per
// whole year past 1970, and the month loop, which steps once per month index; the two loops
// step at most 146 times together.
// Busy stays high through the result cycle, so a new transaction is taken only after the last
// result has been given; results cannot stall. Synchronous active-high reset idles the block.
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hours,
   output logic [5:0]  rsp_minutes,
   output logic [5:0]  rsp_seconds,
   output logic [2:0]  rsp_weekday
);

   e2c_pkg::cmd_type  cmd;
   e2c_pkg::stat_type stat;

   // Sequencer.
   e2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Arithmetic and result registers.
   e2c_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_epoch_seconds (req_epoch_seconds),
      .stat              (stat),
      .year              (rsp_year),
      .month             (rsp_month),
      .day_of_month      (rsp_day_of_month),
      .hours             (rsp_hours),
      .minutes           (rsp_minutes),
      .seconds           (rsp_seconds),
      .weekday           (rsp_weekday)
   );

   // Delivered time-of-day fields stay in range.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hours <= 5'd23) && (rsp_minutes <= 6'd59) && (rsp_seconds <= 6'd59))
      else $error("time of day out of range");

   // Delivered date fields stay in range.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day_of_month != 5'd0)
                    && (rsp_weekday <= 3'd6))
      else $error("date out of range");

endmodule

// ===== rtl/e2c_datapath.sv =====
// Datapath of the epoch seconds to calendar converter: reciprocal multiply and subtract
// steps for the day, weekday and time of day, year and month subtraction, result registers.
// Depends on e2c_pkg.
module e2c_datapath (
   input  logic              clock,
   input  e2c_pkg::cmd_type  cmd,
   input  logic [31:0]       req_epoch_seconds,
   output e2c_pkg::stat_type stat,
   output logic [11:0]       year,
   output logic [3:0]        month,
   output logic [4:0]        day_of_month,
   output logic [4:0]        hours,
   output logic [5:0]        minutes,
   output logic [5:0]        seconds,
   output logic [2:0]        weekday
);

   logic [31:0] epoch_ff, epoch_in;
   logic [15:0] dayrem_ff, dayrem_in;
   logic [15:0] wk_ff, wk_in;
   logic [13:0] wq_ff, wq_in;
   logic [16:0] sod_ff, sod_in;
   logic [11:0] hrem_ff, hrem_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  hours_ff, hours_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [2:0]  weekday_ff, weekday_in;

   logic [50:0] day_prod;
   logic [32:0] week_prod;
   logic [25:0] hour_prod;
   logic [19:0] min_prod;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;
   logic        year_stop;
   logic        month_stop;

   // Reciprocal products; each quotient is the product shifted right by the reciprocal's k.
   assign day_prod  = {26'd0, epoch_ff[31:7]} * {25'd0, e2c_pkg::DayRecip};
   assign week_prod = {17'd0, wk_ff} * {16'd0, e2c_pkg::WeekRecip};
   assign hour_prod = {13'd0, sod_ff[16:4]} * {12'd0, e2c_pkg::HourRecip};
   assign min_prod  = {10'd0, hrem_ff[11:2]} * {9'd0, e2c_pkg::MinRecip};

   // Leap year test; the 4/100/400 rule reduces to the century check over 1970..2106.
   assign leap     = (year_ff[1:0] == 2'b00) && (year_ff != e2c_pkg::NonLeapCentury);
   assign year_len = 9'd365 + {8'd0, leap};
   assign mon_len  = e2c_pkg::month_len(mon_ff, leap);

   assign year_stop  = dayrem_ff < {7'd0, year_len};
   assign month_stop = (mon_ff == e2c_pkg::LastMonth) || (dayrem_ff < {11'd0, mon_len});

   assign stat.year_stop  = year_stop;
   assign stat.month_stop = month_stop;

   // Next values for every register, chosen by the current command.
   always_comb begin
      epoch_in   = epoch_ff;
      dayrem_in  = dayrem_ff;
      wk_in      = wk_ff;
      wq_in      = wq_ff;
      sod_in     = sod_ff;
      hrem_in    = hrem_ff;
      year_in    = year_ff;
      mon_in     = mon_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      weekday_in = weekday_ff;
      case (cmd.op)
         e2c_pkg::OP_LOAD: begin
            epoch_in = req_epoch_seconds;
         end
         e2c_pkg::OP_DAY: begin
            // Whole days since the epoch.
            dayrem_in = day_prod[50:35];
         end
         e2c_pkg::OP_SOD: begin
            // Second of the day; the true value fits in 17 bits, so the low bits suffice.
            sod_in  = epoch_ff[16:0] - {1'b0, dayrem_ff} * 17'(e2c_pkg::SecsPerDay);
            wk_in   = dayrem_ff + {13'd0, e2c_pkg::EpochWday};
            year_in = e2c_pkg::EpochYear;
         end
         e2c_pkg::OP_HOUR: begin
            hours_in = hour_prod[25:21];
            wq_in    = week_prod[32:19];
         end
         e2c_pkg::OP_HREM: begin
            hrem_in    = sod_ff[11:0] - {7'd0, hours_ff} * 12'(e2c_pkg::SecsPerHour);
            weekday_in = wk_ff[2:0] - wq_ff[2:0] * 3'(e2c_pkg::DaysPerWeek);
         end
         e2c_pkg::OP_MIN: begin
            minutes_in = min_prod[19:14];
         end
         e2c_pkg::OP_SEC: begin
            seconds_in = hrem_ff[5:0] - minutes_ff * 6'(e2c_pkg::SecsPerMin);
            mon_in     = '0;
         end
         e2c_pkg::OP_YEAR: begin
            if (!year_stop) begin
               dayrem_in = dayrem_ff - {7'd0, year_len};
               year_in   = year_ff + 12'd1;
            end
         end
         e2c_pkg::OP_MONTH: begin
            if (!month_stop) begin
               dayrem_in = dayrem_ff - {11'd0, mon_len};
               mon_in    = mon_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      epoch_ff   <= epoch_in;
      dayrem_ff  <= dayrem_in;
      wk_ff      <= wk_in;
      wq_ff      <= wq_in;
      sod_ff     <= sod_in;
      hrem_ff    <= hrem_in;
      year_ff    <= year_in;
      mon_ff     <= mon_in;
      hours_ff   <= hours_in;
      minutes_ff <= minutes_in;
      seconds_ff <= seconds_in;
      weekday_ff <= weekday_in;
   end

   assign year         = year_ff;
   assign month        = mon_ff + 4'd1;
   assign day_of_month = dayrem_ff[4:0] + 5'd1;
   assign hours        = hours_ff;
   assign minutes      = minutes_ff;
   assign seconds      = seconds_ff;
   assign weekday      = weekday_ff;

endmodule

// ===== rtl/e2c_ctrl.sv =====
// Controller of the epoch seconds to calendar converter: sequences the multiply and
// subtract steps, the year and month loops and the result strobe. Depends on e2c_pkg.
module e2c_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  e2c_pkg::stat_type stat,
   output e2c_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);

   e2c_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= e2c_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in  = state_ff;
      cmd.op    = e2c_pkg::OP_NOP;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         e2c_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op   = e2c_pkg::OP_LOAD;
               state_in = e2c_pkg::ST_DAY;
            end
         end
         e2c_pkg::ST_DAY: begin
            cmd.op   = e2c_pkg::OP_DAY;
            state_in = e2c_pkg::ST_SOD;
         end
         e2c_pkg::ST_SOD: begin
            cmd.op   = e2c_pkg::OP_SOD;
            state_in = e2c_pkg::ST_HOUR;
         end
         e2c_pkg::ST_HOUR: begin
            cmd.op   = e2c_pkg::OP_HOUR;
            state_in = e2c_pkg::ST_HREM;
         end
         e2c_pkg::ST_HREM: begin
            cmd.op   = e2c_pkg::OP_HREM;
            state_in = e2c_pkg::ST_MIN;
         end
         e2c_pkg::ST_MIN: begin
            cmd.op   = e2c_pkg::OP_MIN;
            state_in = e2c_pkg::ST_SEC;
         end
         e2c_pkg::ST_SEC: begin
            cmd.op   = e2c_pkg::OP_SEC;
            state_in = e2c_pkg::ST_YEARS;
         end
         e2c_pkg::ST_YEARS: begin
            // The datapath holds its value once the remaining days fit in the year.
            cmd.op = e2c_pkg::OP_YEAR;
            if (stat.year_stop) begin
               state_in = e2c_pkg::ST_MONTHS;
            end
         end
         e2c_pkg::ST_MONTHS: begin
            cmd.op = e2c_pkg::OP_MONTH;
            if (stat.month_stop) begin
               state_in = e2c_pkg::ST_DONE;
            end
         end
         e2c_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = e2c_pkg::ST_IDLE;
         end
         default: begin
            state_in = e2c_pkg::ST_IDLE;
         end
      endcase
   end

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted transaction makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but block not busy");

   // The month loop is entered only after the year loop has stopped.
   a_year_before_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == e2c_pkg::ST_MONTHS)
         |-> $past(stat.year_stop) || $past(state_ff == e2c_pkg::ST_MONTHS))
      else $error("month loop entered before the year loop finished");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar: drives epoch second counts and
// checks every calendar result against a predictor built into this file.
// Depends on the RTL top level only; no package types are needed at the ports.
module testbench;

   // Clock, watchdog and tail figures, and calendar constants for the predictor.
   localparam int          HalfPeriod    = 6;
   localparam int          WatchdogLimit = 2000;
   localparam int          TailCycles    = 220;
   localparam int unsigned DaySecs       = 86400;
   localparam int unsigned HourSecs      = 3600;
   localparam int unsigned MinSecs       = 60;
   localparam int unsigned FirstYear     = 1970;
   localparam int unsigned FirstWeekday  = 4;

   // One expected conversion, tagged with the count that produced it.
   typedef struct packed {
      logic [31:0] epoch;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [2:0]  weekday;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_epoch_seconds = '0;
   logic        busy;
   logic        rsp_valid;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hours;
   logic [5:0]  rsp_minutes;
   logic [5:0]  rsp_seconds;
   logic [2:0]  rsp_weekday;

   calendar_type pending_dates[$];
   int        error_count  = 0;
   int        stall_cycles = 0;
   int        idle_pct     = 6;

   epoch_seconds_to_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hours         (rsp_hours),
      .rsp_minutes       (rsp_minutes),
      .rsp_seconds       (rsp_seconds),
      .rsp_weekday       (rsp_weekday)
   );

   // Free-running clock, 12 ns period.
   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
   function automatic bit year_has_feb29(input int unsigned yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return (yr % 400 == 0);
   endfunction

   // Length of month index mon (0 is January) in year yr.
   function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
      case (mon)
         1:          return year_has_feb29(yr) ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:    return 31;
      endcase
   endfunction

   // Splits a second count into date, time of day and weekday.
   function automatic calendar_type convert_epoch(input logic [31:0] count);
      calendar_type cal;
      int unsigned days;
      int unsigned day_secs;
      int unsigned left;
      int unsigned yr;
      int unsigned mon;
      days     = count / DaySecs;
      day_secs = count % DaySecs;
      left     = days;
      yr       = FirstYear;
      mon      = 0;
      while (left >= (year_has_feb29(yr) ? 366 : 365)) begin
         left -= year_has_feb29(yr) ? 366 : 365;
         yr++;
      end
      while (mon < 11 && left >= days_in_month(mon, yr)) begin
         left -= days_in_month(mon, yr);
         mon++;
      end
      cal.epoch        = count;
      cal.year         = 12'(yr);
      cal.month        = 4'(mon + 1);
      cal.day_of_month = 5'(left + 1);
      cal.hours        = 5'(day_secs / HourSecs);
      cal.minutes      = 6'((day_secs % HourSecs) / MinSecs);
      cal.seconds      = 6'(day_secs % MinSecs);
      cal.weekday      = 3'((days + FirstWeekday) % 7);
      return cal;
   endfunction

   // Second count of midnight on the first day of month mon of year yr (wraps past 2106).
   function automatic logic [31:0] month_start_epoch(input int unsigned yr,
                                                     input int unsigned mon);
      int unsigned days;
      days = 0;
      for (int unsigned y = FirstYear; y < yr; y++) days += year_has_feb29(y) ? 366 : 365;
      for (int unsigned m = 0; m < mon; m++) days += days_in_month(m, yr);
      return 32'(days * DaySecs);
   endfunction

   // Half uniform counts, the rest close to a month boundary or inside a random month.
   function automatic logic [31:0] random_epoch();
      int unsigned pick;
      logic [31:0] base;
      pick = $urandom_range(99);
      if (pick < 50) return $urandom();
      base = month_start_epoch($urandom_range(2106, 1970), $urandom_range(11, 0));
      if (pick < 80) return base + $urandom_range(2 * DaySecs) - DaySecs;
      return base + $urandom_range(31 * DaySecs - 1);
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input logic [31:0] count);
      if (got !== want)
         report_mismatch($sformatf("epoch %0d %s got %0d expected %0d", count, name, got, want));
   endtask

   // Offers one count and holds it until the block takes it, with random gaps before.
   task automatic send_epoch(input logic [31:0] count);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start             <= 1'b1;
      req_epoch_seconds <= count;
      do @(posedge clock); while (busy !== 1'b0);
      pending_dates.push_back(convert_epoch(count));
   endtask

   task automatic release_start();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Holds the sender off until every outstanding transaction has returned.
   task automatic wait_for_results();
      release_start();
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // Zero, the top of the range, the signed 32-bit rollover and two alternating bit patterns.
   task automatic test_range_extremes();
      send_epoch(32'd0);
      send_epoch(32'hFFFF_FFFF);
      send_epoch(32'hFFFF_FFFE);
      send_epoch(32'h7FFF_FFFF);
      send_epoch(32'h8000_0000);
      send_epoch(32'hAAAA_AAAA);
      send_epoch(32'h5555_5555);
   endtask

   // Last second of a day, first of the next, the first hour boundary, end of the first year.
   task automatic test_day_rollover();
      send_epoch(32'd86399);
      send_epoch(32'd86400);
      send_epoch(32'd3599);
      send_epoch(32'd3600);
      send_epoch(32'd31535999);
      send_epoch(32'd31536000);
   endtask

   // Leap days around 1972 and 2000, the non-leap century year 2100 and the start of 2106.
   task automatic test_leap_years();
      send_epoch(32'd68169600);
      send_epoch(32'd94694399);
      send_epoch(32'd951782400);
      send_epoch(32'd951868800);
      send_epoch(32'd4107542399);
      send_epoch(32'd4107542400);
      send_epoch(32'd4133980799);
      send_epoch(32'd4133980800);
      send_epoch(32'd4291747199);
      send_epoch(32'd4291747200);
   endtask

   // Random counts at a given sender idle rate.
   task automatic test_random_dates(input int count, input int pct);
      idle_pct = pct;
      repeat (count) send_epoch(random_epoch());
   endtask

   // Every result strobe is one transaction; compare it with the oldest expectation.
   always @(posedge clock) begin
      calendar_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = pending_dates.pop_front();
            check_field("year", 32'(rsp_year), 32'(want.year), want.epoch);
            check_field("month", 32'(rsp_month), 32'(want.month), want.epoch);
            check_field("day_of_month", 32'(rsp_day_of_month), 32'(want.day_of_month),
                        want.epoch);
            check_field("hours", 32'(rsp_hours), 32'(want.hours), want.epoch);
            check_field("minutes", 32'(rsp_minutes), 32'(want.minutes), want.epoch);
            check_field("seconds", 32'(rsp_seconds), 32'(want.seconds), want.epoch);
            check_field("weekday", 32'(rsp_weekday), 32'(want.weekday), want.epoch);
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either side for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_range_extremes();
      test_day_rollover();
      test_leap_years();
      wait_for_results();

      test_random_dates(560, 6);
      wait_for_results();
      test_random_dates(560, 48);
      wait_for_results();
      test_random_dates(560, 0);
      wait_for_results();

      // Let any stray strobe show up before the verdict.
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0 && pending_dates.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/e2c_pkg.sv
rtl/e2c_datapath.sv
rtl/e2c_ctrl.sv
rtl/epoch_seconds_to_calendar.sv
bench/testbench.sv
